@@ rtl/dfp_pkg.sv @@
// ----------------------------------------------------------------------------
// dfp_pkg
// Shared widths, operation codes, sequencer states and beat structures of the
// depth-first path finder.
// ----------------------------------------------------------------------------
`default_nettype none

package dfp_pkg;

	localparam int VERTEX_W = 5;
	localparam int OP_W     = 2;
	localparam int CFG_W    = 6;

	localparam logic [CFG_W-1:0] COUNT_RESET = 6'd32;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_EDGE  = 2'd1,
		OP_FIND  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_MISS
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [VERTEX_W-1:0] vertex_a;
		logic [VERTEX_W-1:0] vertex_b;
	} cmd_t;

	typedef struct packed {
		logic [VERTEX_W-1:0] vertex;
		logic                path_found;
		logic                last;
	} beat_t;

endpackage

`default_nettype wire

@@ rtl/dfp_ifs.sv @@
// ----------------------------------------------------------------------------
// dfp channel interfaces
// Valid/ready channels for commands, result beats and the vertex count write.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfp_cmd_if import dfp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [VERTEX_W-1:0] vertex_a;
	logic [VERTEX_W-1:0] vertex_b;

	modport source (output valid, operation, vertex_a, vertex_b, input ready);
	modport sink (input valid, operation, vertex_a, vertex_b, output ready);
endinterface

interface dfp_rsp_if import dfp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [VERTEX_W-1:0] vertex;
	logic                path_found;
	logic                last;

	modport source (output valid, vertex, path_found, last, input ready);
	modport sink (input valid, vertex, path_found, last, output ready);
endinterface

interface dfp_cfg_if import dfp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] vertex_count;

	modport source (output valid, vertex_count, input ready);
	modport sink (input valid, vertex_count, output ready);
endinterface

`default_nettype wire

@@ rtl/dfs_path_finder.sv @@
// Edge and clear commands give no result.
// A query examines neighbor candidates through the shared compare unit, backtracks
// by popping the search stack and then emits its result beats; commands wait
// meanwhile.
// Result beats leave through an output register that the search can fill ahead.
// Asynchronous reset empties the graph and sets the vertex count to 32.
// ----------------------------------------------------------------------------
// dfs_path_finder
// Undirected graph store with a depth-first path search, reporting the path
// from the end vertex back to the start vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_path_finder import dfp_pkg::*; #(
	parameter int MAX_VERTICES = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	dfp_cfg_if.sink   cfg,
	dfp_cmd_if.sink   cmd,
	dfp_rsp_if.source rsp
);

	// Vertex fields can name at most 2**VERTEX_W vertices.
	localparam int ROWS = (MAX_VERTICES < (1 << VERTEX_W)) ? MAX_VERTICES : (1 << VERTEX_W);

	logic [CFG_W-1:0] vertex_count_q;
	logic [CFG_W-1:0] n_eff;
	cmd_t             cmd_data;
	logic             beat_valid, beat_ready;
	beat_t            beat_data;
	logic             rsp_valid_q;
	beat_t            rsp_data_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= COUNT_RESET;
		end else if (cfg.valid) begin
			vertex_count_q <= cfg.vertex_count;
		end
	end

	assign n_eff = (vertex_count_q > CFG_W'(ROWS)) ? CFG_W'(ROWS) : vertex_count_q;

	assign cmd_data.operation = cmd.operation;
	assign cmd_data.vertex_a  = cmd.vertex_a;
	assign cmd_data.vertex_b  = cmd.vertex_b;

	dfp_search #(
		.ROWS (ROWS)
	) u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd.valid),
		.cmd_ready  (cmd.ready),
		.cmd_data   (cmd_data),
		.count      (n_eff),
		.beat_valid (beat_valid),
		.beat_ready (beat_ready),
		.beat_data  (beat_data)
	);

	assign beat_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (beat_ready) begin
			rsp_valid_q <= beat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_valid && beat_ready) begin
			rsp_data_q <= beat_data;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.vertex     = rsp_data_q.vertex;
	assign rsp.path_found = rsp_data_q.path_found;
	assign rsp.last       = rsp_data_q.last;

endmodule

`default_nettype wire

@@ rtl/dfp_search.sv @@
// ----------------------------------------------------------------------------
// dfp_search
// Adjacency matrix, visited set, explicit search stack and the sequencer that
// steps one neighbor candidate per cycle through a single compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module dfp_search import dfp_pkg::*; #(
	parameter int ROWS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd_data,
	input  logic [CFG_W-1:0] count,
	output logic             beat_valid,
	input  logic             beat_ready,
	output beat_t            beat_data
);

	localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CNT_W = $clog2(ROWS + 1);

	state_t state_q, state_d;

	logic [ROWS-1:0]  adj_q [ROWS];
	logic [ROWS-1:0]  visited_q;
	logic [IDX_W-1:0] stk_v_q [ROWS];
	logic [CNT_W-1:0] stk_n_q [ROWS];
	logic [CNT_W-1:0] depth_q;
	logic [CNT_W-1:0] cur_i_q;
	logic [IDX_W-1:0] cur_v_q;
	logic [IDX_W-1:0] end_q;
	logic [CFG_W-1:0] n_q;

	logic [IDX_W-1:0] a_idx, b_idx, i_idx, rd_idx, top_idx, push_idx;
	logic [CNT_W-1:0] rd_cnt, top_cnt;
	logic             a_ok, b_ok, i_live, cand;
	logic [ROWS-1:0]  cur_row;
	logic [IDX_W-1:0] rd_v;
	logic [CNT_W-1:0] rd_n;

	logic do_clear, do_edge, do_start, do_push, do_next, do_pop, do_emit, do_done;

	assign a_idx = cmd_data.vertex_a[IDX_W-1:0];
	assign b_idx = cmd_data.vertex_b[IDX_W-1:0];
	assign a_ok  = CFG_W'(cmd_data.vertex_a) < count;
	assign b_ok  = CFG_W'(cmd_data.vertex_b) < count;

	// The candidate compare unit: one neighbor index of the top vertex per cycle.
	assign cur_row = adj_q[cur_v_q];
	assign i_idx   = cur_i_q[IDX_W-1:0];
	assign i_live  = CFG_W'(cur_i_q) < n_q;
	assign cand    = cur_row[i_idx] && (i_idx != cur_v_q) && !visited_q[i_idx];

	// One stack read port: the parent frame while scanning, the top while emitting.
	assign rd_cnt   = (state_q == ST_EMIT) ? depth_q - CNT_W'(1) : depth_q - CNT_W'(2);
	assign rd_idx   = rd_cnt[IDX_W-1:0];
	assign rd_v     = stk_v_q[rd_idx];
	assign rd_n     = stk_n_q[rd_idx];
	assign top_cnt  = depth_q - CNT_W'(1);
	assign top_idx  = top_cnt[IDX_W-1:0];
	assign push_idx = depth_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd_ready  = 1'b0;
		beat_valid = 1'b0;
		beat_data  = '0;
		do_clear   = 1'b0;
		do_edge    = 1'b0;
		do_start   = 1'b0;
		do_push    = 1'b0;
		do_next    = 1'b0;
		do_pop     = 1'b0;
		do_emit    = 1'b0;
		do_done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					case (cmd_data.operation)
						OP_CLEAR: do_clear = 1'b1;
						OP_EDGE:  do_edge = a_ok && b_ok;
						OP_FIND: begin
							if (a_ok && b_ok) begin
								do_start = 1'b1;
								state_d  = ST_SCAN;
							end else begin
								state_d = ST_MISS;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (cur_v_q == end_q) begin
					state_d = ST_EMIT;
				end else if (i_live) begin
					do_push = cand;
					do_next = !cand;
				end else if (depth_q == CNT_W'(1)) begin
					state_d = ST_MISS;
				end else begin
					do_pop = 1'b1;
				end
			end
			ST_EMIT: begin
				beat_valid           = 1'b1;
				beat_data.vertex     = VERTEX_W'(rd_v);
				beat_data.path_found = 1'b1;
				beat_data.last       = (depth_q == CNT_W'(1));
				if (beat_ready) begin
					do_emit = 1'b1;
					if (depth_q == CNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_MISS: begin
				beat_valid     = 1'b1;
				beat_data.last = 1'b1;
				if (beat_ready) begin
					do_done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			visited_q <= '0;
			for (int r = 0; r < ROWS; r++) begin
				adj_q[r] <= '0;
			end
		end else begin
			if (do_clear) begin
				for (int r = 0; r < ROWS; r++) begin
					adj_q[r] <= '0;
				end
			end
			if (do_edge) begin
				adj_q[a_idx][b_idx] <= 1'b1;
				adj_q[b_idx][a_idx] <= 1'b1;
			end
			if (do_start) begin
				visited_q <= ROWS'(1) << a_idx;
				depth_q   <= CNT_W'(1);
			end
			if (do_push) begin
				visited_q[i_idx] <= 1'b1;
				depth_q          <= depth_q + CNT_W'(1);
			end
			if (do_pop || do_emit) begin
				depth_q <= depth_q - CNT_W'(1);
			end
			if (do_done) begin
				depth_q <= '0;
			end
		end
	end

	// The parent keeps the index to resume from when the child frame is popped.
	always_ff @(posedge clk) begin
		if (do_start) begin
			stk_v_q[0] <= a_idx;
			cur_v_q    <= a_idx;
			cur_i_q    <= '0;
			end_q      <= b_idx;
			n_q        <= count;
		end
		if (do_push) begin
			stk_n_q[top_idx]  <= cur_i_q + CNT_W'(1);
			stk_v_q[push_idx] <= i_idx;
			cur_v_q           <= i_idx;
			cur_i_q           <= '0;
		end
		if (do_next) begin
			cur_i_q <= cur_i_q + CNT_W'(1);
		end
		if (do_pop) begin
			cur_v_q <= rd_v;
			cur_i_q <= rd_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_EMIT) |-> CFG_W'(depth_q) <= n_q)
		else $error("search stack deeper than the vertex count");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> visited_q[cur_v_q])
		else $error("current search vertex is not marked visited");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> depth_q == '0)
		else $error("stack not empty while idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> $countones(visited_q) == $countones($past(visited_q)) + 1)
		else $error("push did not mark exactly one new vertex");

	assert property (@(posedge clk) disable iff (!arst_n)
		beat_valid && beat_ready && beat_data.last |=> state_q == ST_IDLE)
		else $error("sequencer busy after the last beat of a query");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the depth-first path finder. A directed table covers
// the corner cases, then random graphs are built and queried under several
// vertex counts and handshake idle patterns. Every result beat is compared
// against a software search of the same graph or a typed expected beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import dfp_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          NUM_VERTICES  = 32;
	localparam int          QUIET_CYCLES  = 24;
	localparam int          STALL_LIMIT   = 20000;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          RANDOM_ITEMS  = 310;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef enum {ROW_CMD, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic [OP_W-1:0]     op;
		logic [VERTEX_W-1:0] a;
		logic [VERTEX_W-1:0] b;
		bit                  typed;
		beat_t               beat;
		logic [CFG_W-1:0]    count;
	} step_t;

	logic clk;
	logic arst_n;

	dfp_cfg_if cfg_if ();
	dfp_cmd_if cmd_if ();
	dfp_rsp_if rsp_if ();

	dfs_path_finder #(
		.MAX_VERTICES(NUM_VERTICES)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_if),
		.cmd   (cmd_if),
		.rsp   (rsp_if)
	);

	// Software copy of the graph and of the vertex count register.
	logic [NUM_VERTICES-1:0] graph_rows [NUM_VERTICES];
	logic [CFG_W-1:0]        count_reg;
	beat_t                   path_beats [$];

	int  mismatches;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_request;
	int  hold_left;
	int  idle_cycles;
	beat_t want;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Appends one expected beat at the tail of the queue.
	function automatic void queue_beat(input beat_t b);
		path_beats.insert(path_beats.size(), b);
	endfunction

	function automatic int active_vertices();
		int n;
		n = int'(count_reg);
		if (n > NUM_VERTICES) n = NUM_VERTICES;
		return n;
	endfunction

	// Iterative depth-first search; appends the beats of one query.
	function automatic void predict_path(input logic [VERTEX_W-1:0] a,
		input logic [VERTEX_W-1:0] b);
		int n;
		int depth;
		int top;
		int i;
		bit found;
		bit pushed;
		logic [VERTEX_W-1:0]     v;
		logic [NUM_VERTICES-1:0] seen;
		logic [VERTEX_W-1:0]     stk_vertex [NUM_VERTICES+1];
		int                      stk_next [NUM_VERTICES+1];
		n = active_vertices();
		found = 1'b0;
		if (a >= n || b >= n) begin
			queue_beat('{vertex: '0, path_found: 1'b0, last: 1'b1});
			return;
		end
		seen = '0;
		seen[a] = 1'b1;
		stk_vertex[0] = a;
		stk_next[0] = 0;
		depth = 1;
		while (depth > 0) begin
			top = depth - 1;
			v = stk_vertex[top];
			if (v == b) begin
				found = 1'b1;
				break;
			end
			pushed = 1'b0;
			for (i = stk_next[top]; i < n; i++) begin
				if (i == v) continue;
				if (graph_rows[v][i] && !seen[i]) begin
					stk_next[top] = i + 1;
					seen[i] = 1'b1;
					stk_vertex[depth] = i[VERTEX_W-1:0];
					stk_next[depth] = 0;
					depth++;
					pushed = 1'b1;
					break;
				end
			end
			if (!pushed) begin
				stk_next[top] = n;
				depth--;
			end
		end
		if (!found) begin
			queue_beat('{vertex: '0, path_found: 1'b0, last: 1'b1});
			return;
		end
		for (int d = depth - 1; d >= 0; d--) begin
			queue_beat('{vertex: stk_vertex[d], path_found: 1'b1, last: (d == 0)});
		end
	endfunction

	// Mirror of an accepted command in the software graph and the expected beat queue.
	function automatic void apply_command(input logic [OP_W-1:0] op,
		input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b,
		input bit typed, input beat_t beat);
		int n;
		n = active_vertices();
		case (op)
			OP_CLEAR: begin
				for (int r = 0; r < NUM_VERTICES; r++) graph_rows[r] = '0;
			end
			OP_EDGE: begin
				if (a < n && b < n) begin
					graph_rows[a][b] = 1'b1;
					graph_rows[b][a] = 1'b1;
				end
			end
			OP_FIND: begin
				if (typed) queue_beat(beat);
				else predict_path(a, b);
			end
			default: ;
		endcase
	endfunction

	task automatic send_command(input logic [OP_W-1:0] op,
		input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b,
		input bit typed = 1'b0, input beat_t beat = '0);
		int gap;
		gap = 0;
		if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid     <= 1'b1;
		cmd_if.operation <= op;
		cmd_if.vertex_a  <= a;
		cmd_if.vertex_b  <= b;
		do @(posedge clk); while (!cmd_if.ready);
		apply_command(op, a, b, typed, beat);
	endtask

	// Holds the command channel until every result beat is in and the block
	// has had time to retire any trailing edge or clear.
	task automatic wait_quiet();
		cmd_if.valid <= 1'b0;
		while (path_beats.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [CFG_W-1:0] value);
		cfg_if.valid        <= 1'b1;
		cfg_if.vertex_count <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		count_reg = value;
	endtask

	function automatic step_t row_cmd(input logic [OP_W-1:0] op,
		input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b);
		return '{kind: ROW_CMD, op: op, a: a, b: b, typed: 1'b0, beat: '0, count: '0};
	endfunction

	function automatic step_t row_typed(input logic [VERTEX_W-1:0] a,
		input logic [VERTEX_W-1:0] b, input logic [VERTEX_W-1:0] v, input logic f);
		return '{kind: ROW_CMD, op: OP_FIND, a: a, b: b, typed: 1'b1,
			beat: '{vertex: v, path_found: f, last: 1'b1}, count: '0};
	endfunction

	function automatic step_t row_cfg(input logic [CFG_W-1:0] c);
		return '{kind: ROW_CFG, op: OP_CLEAR, a: '0, b: '0, typed: 1'b0, beat: '0,
			count: c};
	endfunction

	// Picks a vertex that is mostly inside the active range.
	function automatic logic [VERTEX_W-1:0] pick_vertex(input int n);
		if (n < 1 || $urandom_range(99) < 10) return VERTEX_W'($urandom_range(0, 31));
		return VERTEX_W'($urandom_range(0, n - 1));
	endfunction

	// Receiver: random stalls plus an occasional long hold-off.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (path_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat vertex %0d found %0b last %0b",
					rsp_if.vertex, rsp_if.path_found, rsp_if.last));
			end else begin
				want = path_beats.pop_front();
				if (rsp_if.vertex !== want.vertex)
					report_mismatch($sformatf("vertex %0d, wanted %0d",
						rsp_if.vertex, want.vertex));
				if (rsp_if.path_found !== want.path_found)
					report_mismatch($sformatf("path_found %0b, wanted %0b",
						rsp_if.path_found, want.path_found));
				if (rsp_if.last !== want.last)
					report_mismatch($sformatf("last %0b, wanted %0b",
						rsp_if.last, want.last));
			end
		end
	end

	// Watchdog on consecutive cycles without any accepted beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	initial begin
		step_t steps [$];
		int    counts [10];
		int    items;
		int    phase;
		int    phase_items;
		int    n;
		int    edges;
		int    queries;
		arst_n              = 1'b0;
		cfg_if.valid        = 1'b0;
		cfg_if.vertex_count = '0;
		cmd_if.valid        = 1'b0;
		cmd_if.operation    = '0;
		cmd_if.vertex_a     = '0;
		cmd_if.vertex_b     = '0;
		rsp_if.ready        = 1'b0;
		mismatches          = 0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		hold_request        = 1'b0;
		hold_left           = 0;
		idle_cycles         = 0;
		count_reg           = COUNT_RESET;
		for (int r = 0; r < NUM_VERTICES; r++) graph_rows[r] = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting from the reset count of 32.
		steps.insert(steps.size(), row_typed(5'd0, 5'd0, 5'd0, 1'b1));
		steps.insert(steps.size(), row_typed(5'd0, 5'd1, 5'd0, 1'b0));
		steps.insert(steps.size(), row_cmd(OP_EDGE, 5'd0, 5'd1));
		steps.insert(steps.size(), row_cmd(OP_EDGE, 5'd1, 5'd31));
		steps.insert(steps.size(), row_cmd(OP_FIND, 5'd0, 5'd31));
		steps.insert(steps.size(), row_cmd(OP_EDGE, 5'd5, 5'd5));
		steps.insert(steps.size(), row_typed(5'd5, 5'd6, 5'd0, 1'b0));
		steps.insert(steps.size(), row_cmd(OP_FIND, 5'd31, 5'd0));
		steps.insert(steps.size(), row_cmd(OP_UNUSED, 5'd31, 5'd31));
		steps.insert(steps.size(), row_typed(5'd31, 5'd31, 5'd31, 1'b1));
		steps.insert(steps.size(), row_cmd(OP_CLEAR, 5'd31, 5'd31));
		steps.insert(steps.size(), row_typed(5'd0, 5'd31, 5'd0, 1'b0));
		steps.insert(steps.size(), row_cfg(6'd4));
		steps.insert(steps.size(), row_cmd(OP_EDGE, 5'd2, 5'd3));
		steps.insert(steps.size(), row_cmd(OP_EDGE, 5'd3, 5'd4));
		steps.insert(steps.size(), row_cmd(OP_FIND, 5'd2, 5'd3));
		steps.insert(steps.size(), row_typed(5'd4, 5'd0, 5'd0, 1'b0));
		steps.insert(steps.size(), row_typed(5'd0, 5'd4, 5'd0, 1'b0));
		steps.insert(steps.size(), row_cfg(6'd0));
		steps.insert(steps.size(), row_typed(5'd0, 5'd0, 5'd0, 1'b0));
		steps.insert(steps.size(), row_cmd(OP_EDGE, 5'd0, 5'd0));
		steps.insert(steps.size(), row_cfg(6'd63));
		steps.insert(steps.size(), row_cmd(OP_EDGE, 5'd30, 5'd31));
		steps.insert(steps.size(), row_cmd(OP_EDGE, 5'd0, 5'd30));
		steps.insert(steps.size(), row_cmd(OP_FIND, 5'd31, 5'd0));
		steps.insert(steps.size(), row_cmd(OP_FIND, 5'd3, 5'd2));

		foreach (steps[i]) begin
			if (steps[i].kind == ROW_CFG) begin
				wait_quiet();
				write_vertex_count(steps[i].count);
			end else begin
				send_command(steps[i].op, steps[i].a, steps[i].b, steps[i].typed,
					steps[i].beat);
			end
		end

		// Random part: mostly clear, build, then query; some noise items.
		counts = '{32, 8, 5, 63, 1, 16, 2, 33, 12, 32};
		items = 0;
		phase = 0;
		while (items < RANDOM_ITEMS) begin
			wait_quiet();
			write_vertex_count(CFG_W'(counts[phase % 10]));
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			// Long receiver hold-off while commands keep coming.
			if (phase == 2) hold_request = 1'b1;
			n = active_vertices();
			phase_items = 0;
			while (phase_items < 35) begin
				if ($urandom_range(99) < 85) begin
					send_command(OP_CLEAR, VERTEX_W'($urandom_range(0, 31)),
						VERTEX_W'($urandom_range(0, 31)));
					edges = $urandom_range(0, (2 * n < 24) ? 2 * n : 24);
					repeat (edges) send_command(OP_EDGE, pick_vertex(n), pick_vertex(n));
					queries = $urandom_range(1, 4);
					repeat (queries) send_command(OP_FIND, pick_vertex(n), pick_vertex(n));
					phase_items += 1 + edges + queries;
				end else begin
					send_command(OP_W'($urandom_range(0, 3)), VERTEX_W'($urandom_range(0, 31)),
						VERTEX_W'($urandom_range(0, 31)));
					phase_items++;
				end
				// Sender pause until the block has delivered everything.
				if (phase == 3 && phase_items > 15 && phase_items < 30) wait_quiet();
			end
			items += phase_items;
			phase++;
		end

		wait_quiet();
		repeat (QUIET_CYCLES) @(posedge clk);
		if (path_beats.size() != 0)
			report_mismatch($sformatf("%0d beats never arrived", path_beats.size()));
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
